[hdl/pct_pkg.sv]
`timescale 1ns / 1ps

package pct_pkg;

   // Fixed field widths
   localparam int DATA_WIDTH      = 32;
   localparam int REFRESH_WIDTH   = 24;
   localparam int PPR_WIDTH       = 8;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int DIV_COUNT_WIDTH = $clog2(DATA_WIDTH);

   // Default width of the period counter
   localparam int PERIOD_WIDTH_DEFAULT = 24;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REFRESH_PERIOD = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RATE_NUMERATOR = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PULSES_PER_REV = 2'd2;

   // Register reset values
   localparam logic [REFRESH_WIDTH-1:0] REFRESH_PERIOD_RESET = 24'd2990500;
   localparam logic [DATA_WIDTH-1:0]    RATE_NUMERATOR_RESET = 32'd180000000;
   localparam logic [PPR_WIDTH-1:0]     PULSES_PER_REV_RESET = 8'd1;

   // Divider operand select
   typedef enum logic {
      DIV_SEL_RATE = 1'b0,   // rate_numerator / pulses_per_rev
      DIV_SEL_RPM  = 1'b1    // first quotient / captured period
   } div_sel_type;

   // Controller -> datapath
   typedef struct packed {
      logic        tick;        // input transfer this cycle
      logic        div_start;
      div_sel_type div_sel;
      logic        load_out;    // load the result register
      logic        too_slow;    // kind of result being loaded
   } pct_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic refresh_fire;  // this tick ends a refresh period
      logic report_rpm;    // a capture is held at that refresh
      logic div_done;      // divider holds a finished quotient
      logic out_free;      // result register can take a new result
   } pct_sts_type;

endpackage

[hdl/pct_ctrl.sv]
`timescale 1ns / 1ps

module pct_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  pct_pkg::pct_sts_type sts,
   output pct_pkg::pct_cmd_type cmd
);
   import pct_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_RATE,
      ST_DIV_RPM,
      ST_REPORT_RPM,
      ST_REPORT_SLOW
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd.tick      = 1'b0;
      cmd.div_start = 1'b0;
      cmd.div_sel   = DIV_SEL_RATE;
      cmd.load_out  = 1'b0;
      cmd.too_slow  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.tick = 1'b1;
               if (sts.refresh_fire) begin
                  if (sts.report_rpm) begin
                     cmd.div_start = 1'b1;
                     cmd.div_sel   = DIV_SEL_RATE;
                     state_in      = ST_DIV_RATE;
                  end else begin
                     state_in = ST_REPORT_SLOW;
                  end
               end
            end
         end
         ST_DIV_RATE: begin
            if (sts.div_done) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_SEL_RPM;
               state_in      = ST_DIV_RPM;
            end
         end
         ST_DIV_RPM: begin
            if (sts.div_done) begin
               state_in = ST_REPORT_RPM;
            end
         end
         ST_REPORT_RPM: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_REPORT_SLOW: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               cmd.too_slow = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A quotient only finishes while a division is in flight.
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      $rose(sts.div_done) |-> (state_ff == ST_DIV_RATE || state_ff == ST_DIV_RPM))
      else $error("divider finished outside a division state");

endmodule

[hdl/pct_dp.sv]
`timescale 1ns / 1ps

module pct_dp #(
   parameter int PERIOD_WIDTH = pct_pkg::PERIOD_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [pct_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [pct_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   input  logic                                req_sensor_edge,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pct_pkg::DATA_WIDTH-1:0]      rsp_speed_rpm,
   output logic                                rsp_too_slow,
   input  pct_pkg::pct_cmd_type                cmd,
   output pct_pkg::pct_sts_type                sts
);
   import pct_pkg::*;

   // Config registers
   logic [REFRESH_WIDTH-1:0] refresh_period_ff;
   logic [DATA_WIDTH-1:0]    rate_numerator_ff;
   logic [PPR_WIDTH-1:0]     pulses_per_rev_ff;

   // Measurement state
   logic                     first_edge_seen_ff, first_edge_seen_in;
   logic                     capture_done_ff, capture_done_in;
   logic [PERIOD_WIDTH-1:0]  period_counter_ff, period_counter_in;
   logic [PERIOD_WIDTH-1:0]  captured_period_ff, captured_period_in;
   logic [REFRESH_WIDTH-1:0] refresh_counter_ff, refresh_counter_in;

   // Divider
   logic                       div_busy_ff;
   logic                       div_done_ff;
   logic [DIV_COUNT_WIDTH-1:0] div_count_ff;
   logic [DATA_WIDTH-1:0]      div_quo_ff, div_quo_in;
   logic [DATA_WIDTH-1:0]      div_rem_ff, div_rem_in;
   logic [DATA_WIDTH-1:0]      div_divisor_ff;
   logic [DATA_WIDTH:0]        div_shift;
   logic [DATA_WIDTH+1:0]      div_diff;

   // Result register
   logic                  rsp_valid_ff;
   logic [DATA_WIDTH-1:0] rsp_speed_rpm_ff;
   logic                  rsp_too_slow_ff;

   logic                    done_mid;
   logic [PERIOD_WIDTH-1:0] period_inc;
   logic [REFRESH_WIDTH-1:0] refresh_next;
   logic                    fire;

   // Per-tick update: count, handle the edge, then advance refresh
   always_comb begin
      period_inc = period_counter_ff;
      if (first_edge_seen_ff && !capture_done_ff && (period_counter_ff != '1)) begin
         period_inc = period_counter_ff + 1'b1;
      end

      first_edge_seen_in = first_edge_seen_ff;
      period_counter_in  = period_inc;
      captured_period_in = captured_period_ff;
      done_mid           = capture_done_ff;
      if (req_sensor_edge && !capture_done_ff) begin
         if (!first_edge_seen_ff) begin
            first_edge_seen_in = 1'b1;
            period_counter_in  = '0;
         end else begin
            captured_period_in = period_inc;
            first_edge_seen_in = 1'b0;
            done_mid           = 1'b1;
         end
      end

      refresh_next       = refresh_counter_ff + 1'b1;
      fire               = (refresh_next == refresh_period_ff);
      refresh_counter_in = fire ? '0 : refresh_next;
      capture_done_in    = fire ? 1'b0 : done_mid;
   end

   assign sts.refresh_fire = fire;
   assign sts.report_rpm   = done_mid;
   assign sts.div_done     = div_done_ff;
   assign sts.out_free     = !rsp_valid_ff || rsp_ready;

   // Restoring division step, one quotient bit per cycle
   always_comb begin
      div_shift = {div_rem_ff, div_quo_ff[DATA_WIDTH-1]};
      div_diff  = {1'b0, div_shift} - {2'b00, div_divisor_ff};
      if (!div_diff[DATA_WIDTH+1]) begin
         div_rem_in = div_diff[DATA_WIDTH-1:0];
         div_quo_in = {div_quo_ff[DATA_WIDTH-2:0], 1'b1};
      end else begin
         div_rem_in = div_shift[DATA_WIDTH-1:0];
         div_quo_in = {div_quo_ff[DATA_WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         refresh_period_ff  <= REFRESH_PERIOD_RESET;
         rate_numerator_ff  <= RATE_NUMERATOR_RESET;
         pulses_per_rev_ff  <= PULSES_PER_REV_RESET;
         first_edge_seen_ff <= 1'b0;
         capture_done_ff    <= 1'b0;
         period_counter_ff  <= '0;
         captured_period_ff <= '0;
         refresh_counter_ff <= '0;
         div_busy_ff        <= 1'b0;
         div_done_ff        <= 1'b0;
         div_count_ff       <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_REFRESH_PERIOD: refresh_period_ff <= csr_data[REFRESH_WIDTH-1:0];
               CSR_RATE_NUMERATOR: rate_numerator_ff <= csr_data[DATA_WIDTH-1:0];
               CSR_PULSES_PER_REV: pulses_per_rev_ff <= csr_data[PPR_WIDTH-1:0];
               default: ;
            endcase
         end

         if (cmd.tick) begin
            first_edge_seen_ff <= first_edge_seen_in;
            capture_done_ff    <= capture_done_in;
            period_counter_ff  <= period_counter_in;
            captured_period_ff <= captured_period_in;
            refresh_counter_ff <= refresh_counter_in;
         end

         if (cmd.div_start) begin
            div_busy_ff  <= 1'b1;
            div_done_ff  <= 1'b0;
            div_count_ff <= '0;
         end else if (div_busy_ff) begin
            div_count_ff <= div_count_ff + 1'b1;
            if (div_count_ff == DIV_COUNT_WIDTH'(DATA_WIDTH - 1)) begin
               div_busy_ff <= 1'b0;
               div_done_ff <= 1'b1;
            end
         end

         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Divider payload
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_rem_ff <= '0;
         if (cmd.div_sel == DIV_SEL_RATE) begin
            div_quo_ff     <= rate_numerator_ff;
            div_divisor_ff <= DATA_WIDTH'(pulses_per_rev_ff);
         end else begin
            div_quo_ff     <= div_quo_ff;
            div_divisor_ff <= DATA_WIDTH'(captured_period_ff);
         end
      end else if (div_busy_ff) begin
         div_rem_ff <= div_rem_in;
         div_quo_ff <= div_quo_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_speed_rpm_ff <= cmd.too_slow ? '0 : div_quo_ff;
         rsp_too_slow_ff  <= cmd.too_slow;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_speed_rpm = rsp_speed_rpm_ff;
   assign rsp_too_slow  = rsp_too_slow_ff;

   a_div_state: assert property (@(posedge clock) disable iff (reset)
      !(div_busy_ff && div_done_ff))
      else $error("divider busy and done together");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   a_period_nonzero: assert property (@(posedge clock) disable iff (reset)
      capture_done_ff |-> (captured_period_ff != '0))
      else $error("held capture has zero period");

endmodule

[hdl/period_capture_tachometer_unit.sv]
`timescale 1ns / 1ps

// Channel  Handshake               Payload
// req      req_valid / req_ready   req_sensor_edge (one timer tick)
// rsp      rsp_valid / rsp_ready   rsp_speed_rpm[31:0], rsp_too_slow
// csr      csr_valid / csr_ready   csr_index[1:0], csr_data[31:0]
//
// Ordinary ticks transfer back to back.
// A refresh tick with a held capture is accepted, then the shared one-bit-per-cycle
// divider runs numerator/pulses; once it is seen done it restarts on quotient/period,
// and once that is seen done the result is loaded.
// A refresh tick without a capture goes straight to loading a too-slow result.
// The result register drains independently; a stalled rsp side holds the block
// only when a new report is ready to load. Reset is synchronous, active high.

module period_capture_tachometer_unit #(
   parameter int PERIOD_WIDTH = pct_pkg::PERIOD_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // tick input
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_sensor_edge,
   // speed report
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pct_pkg::DATA_WIDTH-1:0]      rsp_speed_rpm,
   output logic                                rsp_too_slow,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pct_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [pct_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import pct_pkg::*;

   pct_cmd_type cmd;
   pct_sts_type sts;

   // Register writes are always accepted; indexes past the last are dropped.
   assign csr_ready = 1'b1;

   // Sequencer: tick acceptance, divider passes, result load
   pct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Counters, capture, config registers, divider and result register
   pct_dp #(
      .PERIOD_WIDTH (PERIOD_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_sensor_edge (req_sensor_edge),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_speed_rpm   (rsp_speed_rpm),
      .rsp_too_slow    (rsp_too_slow),
      .cmd             (cmd),
      .sts             (sts)
   );

endmodule
